// ===== src/sled_pkg.sv =====
// Package for the string literal escape decoder.
// Holds the word types, mode and code constants shared by all modules.
// No dependencies.
`default_nettype none

package sled_pkg;

	// Input word: one source character or end of source
	typedef struct packed {
		logic [20:0] code_point;
		logic        end_of_input;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [1:0]  out_kind;
		logic [20:0] out_char;
		logic [1:0]  error_code;
		logic        newline_seen;
		logic        last;
	} out_word_t;

	// Decoder mode; the unused code is handled as normal text
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_HEX    = 2'd2
	} mode_t;

	// Result kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
	localparam logic [1:0] ERR_UNEXP_END = 2'd3;

	// Source characters of interest
	localparam logic [20:0] CH_QUOTE     = 21'h22;
	localparam logic [20:0] CH_APOS      = 21'h27;
	localparam logic [20:0] CH_BACKSLASH = 21'h5C;
	localparam logic [20:0] CH_LF        = 21'h0A;
	localparam logic [20:0] CH_ZERO      = 21'h30;
	localparam logic [20:0] CH_A_LOW     = 21'h61;
	localparam logic [20:0] CH_B_LOW     = 21'h62;
	localparam logic [20:0] CH_T_LOW     = 21'h74;
	localparam logic [20:0] CH_N_LOW     = 21'h6E;
	localparam logic [20:0] CH_V_LOW     = 21'h76;
	localparam logic [20:0] CH_F_LOW     = 21'h66;
	localparam logic [20:0] CH_R_LOW     = 21'h72;
	localparam logic [20:0] CH_U_LOW     = 21'h75;
	localparam logic [20:0] CH_U_UP      = 21'h55;

	// Control codes produced by escapes
	localparam logic [20:0] CODE_NUL = 21'h00;
	localparam logic [20:0] CODE_BEL = 21'h07;
	localparam logic [20:0] CODE_BS  = 21'h08;
	localparam logic [20:0] CODE_HT  = 21'h09;
	localparam logic [20:0] CODE_LF  = 21'h0A;
	localparam logic [20:0] CODE_VT  = 21'h0B;
	localparam logic [20:0] CODE_FF  = 21'h0C;
	localparam logic [20:0] CODE_CR  = 21'h0D;

	// Result queue depth
	localparam int RQ_DEPTH = 4;

	// Decoder output for one input word: up to two results
	typedef struct packed {
		out_word_t  r0;
		out_word_t  r1;
		logic [1:0] count;
	} dec_result_t;

endpackage

`default_nettype wire

// ===== src/sled_decode.sv =====
// Decode step of the string literal escape decoder.
// Holds the mode, escape value and digit count; uses sled_pkg.
`default_nettype none

module sled_decode #(
	parameter int HEX_DIGITS = 5
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sled_pkg::in_word_t    item,
	input  wire                   fire,
	output sled_pkg::dec_result_t res
);
	import sled_pkg::*;

	localparam int DCW = $clog2(HEX_DIGITS + 1);

	mode_t           mode_q, mode_d;
	logic [19:0]     escape_value_q, escape_value_d;
	logic [DCW-1:0]  digit_count_q, digit_count_d;

	logic [20:0]     c;
	logic [4:0]      hex_d;
	out_word_t       nres;
	logic            n_emit;
	logic            n_esc;

	assign c = item.code_point;

	// Hex digit value; bit 4 flags a non-digit
	always_comb begin
		if (c >= 21'h30 && c <= 21'h39) begin
			hex_d = {1'b0, c[3:0]};
		end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
			hex_d = {1'b0, c[3:0] + 4'd9};
		end else begin
			hex_d = 5'b10000;
		end
	end

	// Normal text handling of the current character
	always_comb begin
		nres   = '0;
		n_emit = 1'b1;
		n_esc  = 1'b0;
		if (c == CH_QUOTE) begin
			nres.out_kind = KIND_END;
		end else if (c == CH_BACKSLASH) begin
			n_emit = 1'b0;
			n_esc  = 1'b1;
		end else begin
			nres.out_kind     = KIND_CHAR;
			nres.out_char     = c;
			nres.newline_seen = (c == CH_LF);
		end
	end

	// Next state and results
	always_comb begin
		res            = '0;
		mode_d         = mode_q;
		escape_value_d = escape_value_q;
		digit_count_d  = digit_count_q;
		if (item.end_of_input) begin
			res.r0.out_kind   = KIND_ERROR;
			res.r0.error_code = ERR_UNEXP_END;
			res.count         = 2'd1;
			mode_d            = MODE_NORMAL;
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d    = MODE_NORMAL;
					res.count = 2'd1;
					res.r0.out_kind = KIND_CHAR;
					case (c) inside
						CH_APOS, CH_QUOTE, CH_BACKSLASH: res.r0.out_char = c;
						CH_ZERO:  res.r0.out_char = CODE_NUL;
						CH_A_LOW: res.r0.out_char = CODE_BEL;
						CH_B_LOW: res.r0.out_char = CODE_BS;
						CH_T_LOW: res.r0.out_char = CODE_HT;
						CH_N_LOW: res.r0.out_char = CODE_LF;
						CH_V_LOW: res.r0.out_char = CODE_VT;
						CH_F_LOW: res.r0.out_char = CODE_FF;
						CH_R_LOW: res.r0.out_char = CODE_CR;
						CH_U_LOW, CH_U_UP: begin
							res.count      = 2'd0;
							res.r0         = '0;
							mode_d         = MODE_HEX;
							escape_value_d = '0;
							digit_count_d  = '0;
						end
						default: begin
							res.r0.out_kind   = KIND_ERROR;
							res.r0.error_code = ERR_UNKNOWN;
						end
					endcase
				end
				MODE_HEX: begin
					if (digit_count_q >= DCW'(HEX_DIGITS)) begin
						// Emit the code, then treat the character as text
						res.r0.out_kind = KIND_CHAR;
						res.r0.out_char = {1'b0, escape_value_q};
						res.r1          = nres;
						res.count       = n_emit ? 2'd2 : 2'd1;
						mode_d          = n_esc ? MODE_ESC : MODE_NORMAL;
					end else if (hex_d[4]) begin
						res.r0.out_kind   = KIND_ERROR;
						res.r0.error_code = ERR_BAD_HEX;
						res.count         = 2'd1;
						mode_d            = MODE_NORMAL;
					end else begin
						escape_value_d = {escape_value_q[15:0], hex_d[3:0]};
						digit_count_d  = digit_count_q + DCW'(1);
					end
				end
				default: begin
					res.r0    = nres;
					res.count = n_emit ? 2'd1 : 2'd0;
					mode_d    = n_esc ? MODE_ESC : MODE_NORMAL;
				end
			endcase
		end
		// Mark the final result of this word
		if (res.count == 2'd1) begin
			res.r0.last = 1'b1;
		end
		if (res.count == 2'd2) begin
			res.r1.last = 1'b1;
		end
	end

	// Advance state when the word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_NORMAL;
			escape_value_q <= '0;
			digit_count_q  <= '0;
		end else if (fire) begin
			mode_q         <= mode_d;
			escape_value_q <= escape_value_d;
			digit_count_q  <= digit_count_d;
		end
	end

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= DCW'(HEX_DIGITS))
		else $error("digit count beyond hex digit limit");

	a_end_to_normal: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_input |=> mode_q == MODE_NORMAL)
		else $error("end of input did not return to normal mode");

	a_two_only_hex: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> mode_q == MODE_HEX && !item.end_of_input)
		else $error("two results outside hex completion");

endmodule

`default_nettype wire

// ===== src/sled_result_queue.sv =====
// Result queue of the string literal escape decoder.
// Takes up to two result words a cycle, hands out one; uses sled_pkg.
`default_nettype none

module sled_result_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sled_pkg::out_word_t w0,
	input  sled_pkg::out_word_t w1,
	input  wire  [1:0]          push,
	output logic                room2,
	output logic                out_valid,
	input  wire                 out_ready,
	output sled_pkg::out_word_t out_data
);
	import sled_pkg::*;

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int CW = $clog2(RQ_DEPTH + 1);

	out_word_t      mem_q [RQ_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (cnt_q <= CW'(RQ_DEPTH - 2));

	// Write incoming results
	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			mem_q[wr_q] <= w0;
		end
		if (push == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= w1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push != 2'd0 |-> cnt_q + CW'(push) <= CW'(RQ_DEPTH))
		else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== src/string_literal_escape_decoder.sv =====
// String literal escape decoder: an input register feeds one decode step that can
// accept a new code point every cycle while the result queue has room. The word after
// the last digit of a Unicode escape can give two results, which leave the output
// channel one at a time; every other word gives zero or one result, so the sustained
// rate is one word per cycle while the output side keeps up, and is set by the single
// read port of the four-entry result queue. A word is taken from the input register
// only when the queue has room for two results. The first result of a word is
// registered in the input register and then in the result queue before it is valid.
// Uses sled_pkg, sled_decode and sled_result_queue.
`default_nettype none

module string_literal_escape_decoder #(
	parameter int HEX_DIGITS = 5
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sled_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output sled_pkg::out_word_t out_data
);
	import sled_pkg::*;

	in_word_t     item_s1;
	logic         valid_s1;
	logic         consume;
	logic         room2;
	dec_result_t  res;
	logic [1:0]   push;

	assign consume  = valid_s1 && room2;
	assign in_ready = !valid_s1 || consume;
	assign push     = consume ? res.count : 2'd0;

	// Hold the input word until decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sled_decode #(
		.HEX_DIGITS(HEX_DIGITS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (consume),
		.res    (res)
	);

	sled_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.w0        (res.r0),
		.w1        (res.r1),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("input stage dropped a waiting word");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for string_literal_escape_decoder: random and directed source words,
// random gaps on both channels, results checked in order against an in-bench decoder.
// Depends on sled_pkg and the decoder RTL.

module tb;
	import sled_pkg::*;

	localparam int HEX_DIGITS     = 5;
	localparam int RANDOM_WORDS   = 1200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data  = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// Decoder state mirrored in the bench
	mode_t       dec_mode;
	logic [19:0] esc_val;
	logic [2:0]  digit_cnt;

	in_word_t  source_words[$];
	out_word_t decoded_words[$];

	int words_total;
	int words_taken  = 0;
	int errors       = 0;
	int chars_seen   = 0;
	int ends_seen    = 0;
	int errs_seen    = 0;
	int idle_cycles  = 0;
	int in_gap       = 0;
	int out_gap      = 0;
	int in_calm      = 0;
	int out_calm     = 0;
	bit in_took      = 1'b0;
	bit timed_out    = 1'b0;

	string_literal_escape_decoder #(
		.HEX_DIGITS(HEX_DIGITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic out_word_t make_result(input logic [1:0] kind, input logic [20:0] ch,
			input logic [1:0] err, input logic nl);
		out_word_t r;
		r.out_kind     = kind;
		r.out_char     = ch;
		r.error_code   = err;
		r.newline_seen = nl;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic int hex_digit_value(input logic [20:0] c);
		if (c >= 21'h30 && c <= 21'h39)
			return int'(c) - 'h30;
		if (c >= 21'h41 && c <= 21'h46)
			return int'(c) - 'h41 + 10;
		if (c >= 21'h61 && c <= 21'h66)
			return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	// Plain text handling; returns 1 when the character yields a result
	function automatic bit text_char(input logic [20:0] c, output out_word_t r);
		r = '0;
		dec_mode = MODE_NORMAL;
		if (c == CH_QUOTE) begin
			r = make_result(KIND_END, '0, ERR_NONE, 1'b0);
			return 1'b1;
		end
		if (c == CH_BACKSLASH) begin
			dec_mode = MODE_ESC;
			return 1'b0;
		end
		r = make_result(KIND_CHAR, c, ERR_NONE, c == CH_LF);
		return 1'b1;
	endfunction

	// Advance the decoder by one source word and queue the results it yields
	task automatic decode_word(input in_word_t w);
		out_word_t   res [2];
		int          n;
		int          hv;
		logic [20:0] c;
		c = w.code_point;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (w.end_of_input) begin
			res[0] = make_result(KIND_ERROR, '0, ERR_UNEXP_END, 1'b0);
			dec_mode = MODE_NORMAL;
			n = 1;
		end else begin
			case (dec_mode)
			MODE_ESC: begin
				dec_mode = MODE_NORMAL;
				n = 1;
				case (c)
				CH_QUOTE, CH_APOS, CH_BACKSLASH:
					res[0] = make_result(KIND_CHAR, c, ERR_NONE, 1'b0);
				CH_ZERO:  res[0] = make_result(KIND_CHAR, CODE_NUL, ERR_NONE, 1'b0);
				CH_A_LOW: res[0] = make_result(KIND_CHAR, CODE_BEL, ERR_NONE, 1'b0);
				CH_B_LOW: res[0] = make_result(KIND_CHAR, CODE_BS, ERR_NONE, 1'b0);
				CH_T_LOW: res[0] = make_result(KIND_CHAR, CODE_HT, ERR_NONE, 1'b0);
				CH_N_LOW: res[0] = make_result(KIND_CHAR, CODE_LF, ERR_NONE, 1'b0);
				CH_V_LOW: res[0] = make_result(KIND_CHAR, CODE_VT, ERR_NONE, 1'b0);
				CH_F_LOW: res[0] = make_result(KIND_CHAR, CODE_FF, ERR_NONE, 1'b0);
				CH_R_LOW: res[0] = make_result(KIND_CHAR, CODE_CR, ERR_NONE, 1'b0);
				CH_U_LOW, CH_U_UP: begin
					esc_val   = '0;
					digit_cnt = '0;
					dec_mode  = MODE_HEX;
					n = 0;
				end
				default: res[0] = make_result(KIND_ERROR, '0, ERR_UNKNOWN, 1'b0);
				endcase
			end
			MODE_HEX: begin
				if (digit_cnt >= HEX_DIGITS) begin
					// emit the code, then treat this character as plain text
					res[0] = make_result(KIND_CHAR, {1'b0, esc_val}, ERR_NONE, 1'b0);
					n = text_char(c, res[1]) ? 2 : 1;
				end else begin
					hv = hex_digit_value(c);
					if (hv < 0) begin
						res[0] = make_result(KIND_ERROR, '0, ERR_BAD_HEX, 1'b0);
						dec_mode = MODE_NORMAL;
						n = 1;
					end else begin
						esc_val   = {esc_val[15:0], hv[3:0]};
						digit_cnt = digit_cnt + 3'd1;
					end
				end
			end
			default: n = text_char(c, res[0]) ? 1 : 0;
			endcase
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			decoded_words.push_back(res[i]);
	endtask

	// Mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 8) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	function automatic logic [20:0] escape_letter(input int idx);
		case (idx)
		0:       return CH_QUOTE;
		1:       return CH_APOS;
		2:       return CH_BACKSLASH;
		3:       return CH_ZERO;
		4:       return CH_A_LOW;
		5:       return CH_B_LOW;
		6:       return CH_T_LOW;
		7:       return CH_N_LOW;
		8:       return CH_V_LOW;
		9:       return CH_F_LOW;
		default: return CH_R_LOW;
		endcase
	endfunction

	// Characters that are neither hex digits nor escape letters
	function automatic logic [20:0] odd_char(input int idx);
		case (idx)
		0:       return 21'h67; // g
		1:       return 21'h47; // G
		2:       return 21'h2F; // slash, just below the digits
		3:       return 21'h3A; // colon, just above the digits
		4:       return 21'h40; // just below A
		5:       return 21'h60; // just below a
		6:       return 21'h78; // x
		7:       return 21'h71; // q
		8:       return 21'h20; // space
		default: return CH_LF;
		endcase
	endfunction

	function automatic logic [20:0] hex_char(input int v);
		if (v < 10)
			return 21'('h30 + v);
		if ($urandom_range(0, 1))
			return 21'('h41 + v - 10);
		return 21'('h61 + v - 10);
	endfunction

	task automatic push_char(input logic [20:0] c);
		in_word_t w;
		w.code_point   = c;
		w.end_of_input = 1'b0;
		source_words.push_back(w);
	endtask

	task automatic push_end();
		in_word_t w;
		w.code_point   = 21'($urandom);
		w.end_of_input = 1'b1;
		source_words.push_back(w);
	endtask

	// Append one random token: text, escape, Unicode escape, quote, end or noise
	task automatic add_token();
		int       r;
		int       bad_pos;
		in_word_t w;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				push_char(21'($urandom_range(21'h20, 21'h7E)));
			else if (r < 65)
				push_char(CH_LF);
			else if (r < 85)
				push_char(21'($urandom_range(0, 21'h1FFFFF)));
			else
				push_char(21'($urandom_range(21'h80, 21'h10FFFF)));
		end else if (r < 60) begin
			push_char(CH_BACKSLASH);
			push_char(escape_letter($urandom_range(0, 10)));
		end else if (r < 76) begin
			push_char(CH_BACKSLASH);
			push_char($urandom_range(0, 1) ? CH_U_LOW : CH_U_UP);
			bad_pos = ($urandom_range(0, 99) < 15) ?
				$urandom_range(0, HEX_DIGITS - 1) : HEX_DIGITS;
			for (int i = 0; i < HEX_DIGITS; i++) begin
				if (i == bad_pos) begin
					push_char(odd_char($urandom_range(0, 5)));
					break;
				end
				push_char(hex_char($urandom_range(0, 15)));
			end
			// end of source right after a full set of digits
			if (bad_pos == HEX_DIGITS && $urandom_range(0, 9) == 0)
				push_end();
		end else if (r < 81) begin
			push_char(CH_BACKSLASH);
			if ($urandom_range(0, 1))
				push_char(21'($urandom_range(21'h80, 21'h1FFFFF)));
			else
				push_char(odd_char($urandom_range(0, 9)));
		end else if (r < 90) begin
			push_char(CH_QUOTE);
		end else if (r < 94) begin
			push_end();
		end else begin
			w.code_point   = 21'($urandom);
			w.end_of_input = 1'($urandom_range(0, 1));
			source_words.push_back(w);
		end
	endtask

	// Input driver: hold the word until taken, then idle or present the next
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			in_valid <= 1'b1;
		end else if (in_gap > 0) begin
			in_gap = in_gap - 1;
			in_valid <= 1'b0;
		end else if (source_words.size() > 0) begin
			in_data  <= source_words.pop_front();
			in_valid <= 1'b1;
			in_gap = pick_gap(in_calm);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Output side: stall at random
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap = out_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_gap = pick_gap(out_calm);
		end
	end

	// Monitor: check results first, then predict from the accepted word
	always @(posedge clk) begin : monitor
		out_word_t want;
		bit        moved;
		moved   = 1'b0;
		in_took = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (decoded_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got kind %0d char %h",
						$time, out_data.out_kind, out_data.out_char);
					$display("    err %0d nl %b last %b",
						out_data.error_code, out_data.newline_seen, out_data.last);
				end else begin
					want = decoded_words.pop_front();
					case (want.out_kind)
					KIND_CHAR: chars_seen++;
					KIND_END:  ends_seen++;
					default:   errs_seen++;
					endcase
					if (out_data.out_kind !== want.out_kind ||
							out_data.out_char !== want.out_char ||
							out_data.error_code !== want.error_code ||
							out_data.newline_seen !== want.newline_seen ||
							out_data.last !== want.last) begin
						errors++;
						$display("%0t: mismatch: expected kind %0d char %h err %0d nl %b last %b",
							$time, want.out_kind, want.out_char, want.error_code,
							want.newline_seen, want.last);
						$display("    got kind %0d char %h err %0d nl %b last %b",
							out_data.out_kind, out_data.out_char,
							out_data.error_code, out_data.newline_seen, out_data.last);
					end
				end
			end
			if (in_valid && in_ready) begin
				moved   = 1'b1;
				in_took = 1'b1;
				words_taken++;
				decode_word(in_data);
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT)
				timed_out = 1'b1;
		end
	end

	initial begin
		dec_mode  = MODE_NORMAL;
		esc_val   = '0;
		digit_cnt = '0;

		// Directed: plain text, extremes, escapes, Unicode escapes and errors
		push_char(21'h41);
		push_char(CH_LF);
		push_char(21'h1FFFFF);
		push_char(21'h000000);
		push_char(CH_BACKSLASH);
		push_char(CH_N_LOW);
		push_char(CH_BACKSLASH);
		push_char(21'h71);
		push_char(CH_BACKSLASH);
		push_char(CH_U_LOW);
		push_char(21'h46);
		push_char(21'h66);
		push_char(21'h30);
		push_char(21'h39);
		push_char(21'h61);
		push_char(CH_QUOTE);
		push_char(CH_BACKSLASH);
		push_char(CH_U_UP);
		push_char(21'h67);
		push_char(CH_BACKSLASH);
		push_char(CH_U_LOW);
		repeat (HEX_DIGITS)
			push_char(hex_char(15));
		push_char(CH_BACKSLASH);
		push_char(CH_T_LOW);
		push_char(CH_BACKSLASH);
		push_end();
		push_char(CH_QUOTE);

		while (source_words.size() < 30 + RANDOM_WORDS)
			add_token();
		words_total = source_words.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!timed_out && (words_taken < words_total || decoded_words.size() != 0))
			@(negedge clk);

		if (timed_out) begin
			$display("%0t: no progress for %0d cycles, %0d results still expected",
				$time, WATCHDOG_LIMIT, decoded_words.size());
			$display("FAIL string_literal_escape_decoder");
			$finish;
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			$display("Decoded %0d source words into %0d characters, %0d string ends, %0d errors",
				words_taken, chars_seen, ends_seen, errs_seen);
			$display("with random gaps on both channels; %0d mismatches", errors);
			if (errors == 0 && decoded_words.size() == 0) begin
				$display("PASS string_literal_escape_decoder");
			end else begin
				$display("FAIL string_literal_escape_decoder");
			end
			$finish;
		end
	end

endmodule
